// ===== rtl/swd_pkg.sv =====
`timescale 1ns / 1ps

package swd_pkg;

    localparam int POS_W  = 32;
    localparam int TIME_W = 32;
    localparam int THR_W  = 32;
    localparam int TMO_W  = 31;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 2;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [TIME_W-1:0]       t_time;
    typedef logic [IDX_W-1:0]        t_cfg_idx;
    typedef logic [CFG_W-1:0]        t_cfg_data;

    typedef enum logic [IDX_W-1:0] {
        REG_SPREAD_THRESHOLD = 2'd0,
        REG_TIMEOUT_MS       = 2'd1,
        REG_COOLDOWN_MS      = 2'd2
    } t_reg_idx;

    localparam logic [THR_W-1:0] SPREAD_THRESHOLD_RST = THR_W'(65536);
    localparam logic [TMO_W-1:0] TIMEOUT_MS_RST       = TMO_W'(2000);
    localparam logic [TMO_W-1:0] COOLDOWN_MS_RST      = TMO_W'(1000);

    typedef struct packed {
        logic [THR_W-1:0] spread_threshold;
        logic [TMO_W-1:0] timeout_ms;
        logic [TMO_W-1:0] cooldown_ms;
    } t_cfg;

endpackage

// ===== rtl/swd_in_if.sv =====
`timescale 1ns / 1ps

interface swd_in_if;
    logic              valid;
    logic              ready;
    swd_pkg::t_pos     position;
    swd_pkg::t_time    now_ms;
    logic              restart;

    modport source (output valid, output position, output now_ms, output restart,
                    input ready);
    modport sink   (input valid, input position, input now_ms, input restart,
                    output ready);
endinterface

// ===== rtl/swd_out_if.sv =====
`timescale 1ns / 1ps

interface swd_out_if;
    logic valid;
    logic ready;
    logic stuck;

    modport source (output valid, output stuck, input ready);
    modport sink   (input valid, input stuck, output ready);
endinterface

// ===== rtl/swd_cfg.sv =====
`timescale 1ns / 1ps

module swd_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  swd_pkg::t_cfg_idx   i_cfg_idx,
    input  swd_pkg::t_cfg_data  i_cfg_data,
    output swd_pkg::t_cfg       o_cfg
);
    import swd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SPREAD_THRESHOLD: n_cfg.spread_threshold = i_cfg_data[THR_W-1:0];
                REG_TIMEOUT_MS:       n_cfg.timeout_ms       = i_cfg_data[TMO_W-1:0];
                REG_COOLDOWN_MS:      n_cfg.cooldown_ms      = i_cfg_data[TMO_W-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spread_threshold <= SPREAD_THRESHOLD_RST;
            r_cfg.timeout_ms       <= TIMEOUT_MS_RST;
            r_cfg.cooldown_ms      <= COOLDOWN_MS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/swd_core.sv =====
`timescale 1ns / 1ps

module swd_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  swd_pkg::t_pos   i_position,
    input  swd_pkg::t_time  i_now_ms,
    input  logic            i_restart,
    input  swd_pkg::t_cfg   i_cfg,
    output logic            o_stuck
);
    import swd_pkg::*;

    logic  r_rearm_pending, n_rearm_pending;
    t_pos  r_window_max,    n_window_max;
    t_pos  r_window_min,    n_window_min;
    t_time r_window_start,  n_window_start;
    logic  r_stuck_flag,    n_stuck_flag;

    t_time                    elapsed;
    logic [TIME_W-1:0]        band_end;
    logic [TIME_W-1:0]        timeout_ext;
    logic                     widen;
    logic                     past_timeout;
    logic signed [POS_W:0]    spread;
    logic                     moved;

    always_comb begin
        elapsed      = i_now_ms - r_window_start;
        timeout_ext  = {1'b0, i_cfg.timeout_ms};
        band_end     = timeout_ext + {1'b0, i_cfg.cooldown_ms};
        widen        = (elapsed > band_end) || (elapsed < timeout_ext);
        past_timeout = elapsed > timeout_ext;

        n_rearm_pending = r_rearm_pending;
        n_window_max    = r_window_max;
        n_window_min    = r_window_min;
        n_window_start  = r_window_start;
        n_stuck_flag    = r_stuck_flag;

        if (widen) begin
            if (i_position > r_window_max) n_window_max = i_position;
            if (i_position < r_window_min) n_window_min = i_position;
        end else begin
            n_window_max = i_position;
            n_window_min = i_position;
        end

        spread = {n_window_max[POS_W-1], n_window_max}
               - {n_window_min[POS_W-1], n_window_min};
        moved  = !spread[POS_W] && (spread[POS_W-1:0] > i_cfg.spread_threshold);

        if (i_restart) begin
            n_rearm_pending = 1'b1;
            n_window_max    = r_window_max;
            n_window_min    = r_window_min;
        end else if (r_rearm_pending) begin
            n_rearm_pending = 1'b0;
            n_window_max    = i_position;
            n_window_min    = i_position;
            n_window_start  = i_now_ms;
            n_stuck_flag    = 1'b0;
        end else if (moved) begin
            n_rearm_pending = 1'b1;
        end else if (past_timeout) begin
            n_stuck_flag = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rearm_pending <= 1'b1;
            r_window_max    <= '0;
            r_window_min    <= '0;
            r_window_start  <= '0;
            r_stuck_flag    <= 1'b0;
        end else if (i_fire) begin
            r_rearm_pending <= n_rearm_pending;
            r_window_max    <= n_window_max;
            r_window_min    <= n_window_min;
            r_window_start  <= n_window_start;
            r_stuck_flag    <= n_stuck_flag;
        end
    end

    assign o_stuck = n_stuck_flag;

endmodule

// ===== rtl/stall_window_detector_unit.sv =====
`timescale 1ns / 1ps
// Path: an accepted word passes the input reg, then the result reg.
// Throughput: one word per cycle while unstalled; window update is combinational.
// Backpressure: the input stage advances whenever the result register is empty
// or being drained, so a stalled output blocks input only when both are full.
// Reset (synchronous, active low): window re-armed, stuck cleared, registers
// return to their defaults, both stages empty.

module stall_window_detector_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    swd_in_if.sink              i_in,
    swd_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  swd_pkg::t_cfg_idx   i_cfg_idx,
    input  swd_pkg::t_cfg_data  i_cfg_data
);
    import swd_pkg::*;

    t_cfg  cfg;

    logic  r_s1_valid;
    t_pos  r_s1_position;
    t_time r_s1_now_ms;
    logic  r_s1_restart;

    logic  r_out_valid;
    logic  r_out_stuck;

    logic  advance;
    logic  core_stuck;

    swd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign advance    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || advance;

    swd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_position (r_s1_position),
        .i_now_ms   (r_s1_now_ms),
        .i_restart  (r_s1_restart),
        .i_cfg      (cfg),
        .o_stuck    (core_stuck)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_position <= i_in.position;
            r_s1_now_ms   <= i_in.now_ms;
            r_s1_restart  <= i_in.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_stuck <= core_stuck;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.stuck = r_out_stuck;

endmodule

// ===== rtl/swd_checker.sv =====
`timescale 1ns / 1ps

module swd_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_stuck
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> (i_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_full_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid && i_out_ready) |=> ##1 i_out_valid)
        else $error("accepted word lost in pipeline");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_stuck)))
        else $error("stalled result word changed");

endmodule

bind stall_window_detector_unit swd_checker u_swd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_stuck (o_out.stuck)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import swd_pkg::*;

    localparam t_cfg_idx REG_UNUSED      = 2'd3;
    localparam int       N_DIR           = 21;
    localparam int       N_PHASE         = 8;
    localparam int       WORDS_PER_PHASE = 194;
    localparam int       DRAIN_CYCLES    = 8;

    typedef struct {
        logic  restart;
        t_pos  position;
        t_time now_ms;
        logic  has_exp;
        logic  exp_stuck;
    } t_dir_row;

    // defaults: threshold 0x10000, timeout 2000, cooldown 1000
    t_dir_row dir_rows [N_DIR] = '{
        '{1'b0, 32'h0000_0000, 32'd0,          1'b1, 1'b0},
        '{1'b0, 32'h0000_8000, 32'd100,        1'b0, 1'b0},
        '{1'b0, 32'h8000_0000, 32'd200,        1'b0, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 32'd300,        1'b1, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 32'd2300,       1'b0, 1'b0},
        '{1'b0, 32'h7FFF_FFFF, 32'd2301,       1'b0, 1'b0},
        '{1'b1, 32'h1234_5678, 32'hFFFF_FFFF,  1'b0, 1'b0},
        '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FF00,  1'b1, 1'b0},
        '{1'b0, 32'hFFFF_FFFF, 32'h0000_0100,  1'b0, 1'b0},
        '{1'b0, 32'h0000_0000, 32'h0000_0BE5,  1'b0, 1'b0},
        '{1'b1, 32'h0000_0000, 32'd0,          1'b0, 1'b0},
        '{1'b1, 32'h7FFF_FFFF, 32'd5,          1'b0, 1'b0},
        '{1'b0, 32'h0000_0000, 32'd1000,       1'b1, 1'b0},
        '{1'b0, 32'h0001_0000, 32'd1500,       1'b0, 1'b0},
        '{1'b0, 32'hFFFF_FFFF, 32'd1600,       1'b0, 1'b0},
        '{1'b0, 32'h8000_0000, 32'd0,          1'b1, 1'b0},
        '{1'b0, 32'h8000_0000, 32'd3000,       1'b0, 1'b0},
        '{1'b0, 32'h8000_0000, 32'd3001,       1'b0, 1'b0},
        '{1'b0, 32'h8001_0001, 32'd3002,       1'b0, 1'b0},
        '{1'b0, 32'h5555_5555, 32'hAAAA_AAAA,  1'b1, 1'b0},
        '{1'b0, 32'hAAAA_AAAA, 32'h5555_5555,  1'b0, 1'b0}
    };

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_cfg_we   = 1'b0;
    t_cfg_idx  i_cfg_idx  = REG_SPREAD_THRESHOLD;
    t_cfg_data i_cfg_data = '0;

    swd_in_if  in_if ();
    swd_out_if out_if ();

    stall_window_detector_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // window tracker mirror
    logic [THR_W-1:0] cfg_thr    = SPREAD_THRESHOLD_RST;
    logic [TMO_W-1:0] cfg_tmo    = TIMEOUT_MS_RST;
    logic [TMO_W-1:0] cfg_cool   = COOLDOWN_MS_RST;
    logic             win_rearm  = 1'b1;
    t_pos             win_max    = '0;
    t_pos             win_min    = '0;
    t_time            win_start  = '0;
    logic             win_stuck  = 1'b0;

    logic  stuck_due [$];
    logic  want_stuck;
    int    errors     = 0;
    int    stall_left = 0;
    bit    calm       = 1'b0;
    t_time cur_ms;
    t_pos  base_pos;

    task automatic report(input string what);
        errors++;
        $display("%0t: %s", $time, what);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic advance_window(input logic rs, input t_pos p, input t_time t,
                                  output logic stuck);
        logic [31:0] elapsed;
        logic [32:0] band_end;
        logic [32:0] spread;
        if (rs) begin
            win_rearm = 1'b1;
        end else if (win_rearm) begin
            win_rearm = 1'b0;
            win_max   = p;
            win_min   = p;
            win_start = t;
            win_stuck = 1'b0;
        end else begin
            elapsed  = t - win_start;
            band_end = {2'b0, cfg_tmo} + {2'b0, cfg_cool};
            if ({1'b0, elapsed} > band_end || elapsed < {1'b0, cfg_tmo}) begin
                if (p > win_max) win_max = p;
                if (p < win_min) win_min = p;
            end else begin
                win_max = p;
                win_min = p;
            end
            spread = {win_max[31], win_max} - {win_min[31], win_min};
            if (spread > {1'b0, cfg_thr}) begin
                win_rearm = 1'b1;
            end else if (elapsed > {1'b0, cfg_tmo}) begin
                win_stuck = 1'b1;
            end
        end
        stuck = win_stuck;
    endtask

    task automatic push_word(input logic rs, input t_pos p, input t_time t,
                             input logic has_exp, input logic exp_stuck);
        int   gap;
        logic predicted;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.restart  <= rs;
        in_if.position <= p;
        in_if.now_ms   <= t;
        do @(posedge i_clk); while (!in_if.ready);
        advance_window(rs, p, t, predicted);
        stuck_due.push_back(has_exp ? exp_stuck : predicted);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (stuck_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg_data thr, input t_cfg_data tmo,
                               input t_cfg_data cool, input bit poke_unused);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SPREAD_THRESHOLD;
        i_cfg_data <= thr;
        @(posedge i_clk);
        i_cfg_idx  <= REG_TIMEOUT_MS;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_idx  <= REG_COOLDOWN_MS;
        i_cfg_data <= cool;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx  <= REG_UNUSED;
            i_cfg_data <= $urandom;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_thr  = thr[THR_W-1:0];
        cfg_tmo  = tmo[TMO_W-1:0];
        cfg_cool = cool[TMO_W-1:0];
    endtask

    // mostly small steps around a drifting base, some jumps and junk
    task automatic next_sample(output logic rs, output t_pos p, output t_time t);
        logic [32:0] span;
        logic [31:0] amp;
        logic [31:0] off;
        int          r;
        r    = $urandom_range(0, 99);
        rs   = (r < 4);
        span = ({2'b0, cfg_tmo} + {2'b0, cfg_cool}) >> 3;
        if (span > 33'd20000) span = 33'd20000;
        if (r >= 4 && r < 10) cur_ms = $urandom;
        else cur_ms = cur_ms + $urandom_range(0, span[31:0] + 2);
        t   = cur_ms;
        amp = cfg_thr >> 1;
        if (amp == 0) amp = 1;
        if (amp > 32'h4000_0000) amp = 32'h4000_0000;
        off = $urandom_range(0, amp);
        r   = $urandom_range(0, 99);
        if (r < 6) base_pos = $urandom;
        if (r < 12) begin
            p = $urandom;
        end else if (r < 30) begin
            p = $urandom_range(0, 1) ? base_pos + amp + off : base_pos - amp - off;
        end else begin
            p = $urandom_range(0, 1) ? base_pos + off : base_pos - off;
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_if.ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (stuck_due.size() == 0) begin
                report("result word with nothing expected");
            end else begin
                want_stuck = stuck_due.pop_front();
                if (out_if.stuck !== want_stuck) begin
                    report($sformatf("stuck %b, expected %b", out_if.stuck, want_stuck));
                end
            end
        end
    end

    initial begin
        logic      rs;
        t_pos      p;
        t_time     t;
        t_cfg_data thr;
        t_cfg_data tmo;
        t_cfg_data cool;
        in_if.valid    = 1'b0;
        in_if.restart  = 1'b0;
        in_if.position = '0;
        in_if.now_ms   = '0;
        out_if.ready   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) begin
            push_word(dir_rows[k].restart, dir_rows[k].position, dir_rows[k].now_ms,
                      dir_rows[k].has_exp, dir_rows[k].exp_stuck);
        end

        for (int ph = 0; ph < N_PHASE; ph++) begin
            thr  = $urandom_range(0, 32'h0010_0000);
            tmo  = {1'($urandom_range(0, 1)), 31'($urandom_range(1, 3000))};
            cool = $urandom_range(0, 3000);
            case (ph)
                0: begin
                    thr = '0; tmo = '0; cool = '0;
                end
                1: begin
                    thr = '1; tmo = '1; cool = '1;
                end
                2: begin
                    thr = 32'h0001_0000; tmo = 32'd2000; cool = 32'd1000;
                end
                5: begin
                    tmo = 32'h7FFF_FFFF; cool = '0;
                end
                default: ;
            endcase
            load_config(thr, tmo, cool, ph == 0);
            calm     = (ph % 3 == 2);
            cur_ms   = $urandom;
            base_pos = $urandom;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                next_sample(rs, p, t);
                push_word(rs, p, t, 1'b0, 1'b0);
            end
        end

        calm = 1'b0;
        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== stall_window_detector_unit.f =====
rtl/swd_pkg.sv
rtl/swd_in_if.sv
rtl/swd_out_if.sv
rtl/swd_cfg.sv
rtl/swd_core.sv
rtl/stall_window_detector_unit.sv
rtl/swd_checker.sv
tb/tb.sv
